>>> src/i2ke_pkg.sv
// shared types, constants and the per-byte conversion rule of the iso-2022-kr converter
package i2ke_pkg;

   localparam logic [7:0] CHAR_ESC    = 8'h1B;
   localparam logic [7:0] CHAR_SO     = 8'h0E;
   localparam logic [7:0] CHAR_SI     = 8'h0F;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] HIGH_BIT    = 8'h80;
   localparam logic [7:0] LOW_MASK    = 8'h7F;
   localparam logic [7:0] LEAD_LO     = 8'hA1;
   localparam logic [7:0] LEAD_HI     = 8'hFE;

   // designator ESC $ ) C, entry 0 first
   localparam logic [3:0][7:0] ESC_SEQ = {8'h43, CHAR_RPAREN, CHAR_DOLLAR, CHAR_ESC};

   localparam int unsigned MAX_WORDS = 4;

   typedef struct packed {
      logic       shift_active;
      logic [1:0] escape_progress;
      logic       pair_waiting;
      logic       pair_is_shifted;
      logic [7:0] held_lead;
   } conv_state_type;

   // words of one rule application, b0 goes out first
   typedef struct packed {
      conv_state_type st;
      logic [1:0]     count;
      logic [7:0]     b1;
      logic [7:0]     b0;
   } step_result_type;

   // words caused by one input byte, entry 0 goes out first
   typedef struct packed {
      logic [2:0]                     count;
      logic [MAX_WORDS-1:0][7:0]      words;
   } word_list_type;

   function automatic step_result_type handle_byte(conv_state_type st, logic [7:0] b,
                                                    logic allow_esc);
      step_result_type r;
      r       = '0;
      r.st    = st;
      if (st.pair_waiting) begin
         r.count = 2'd2;
         if (st.pair_is_shifted) begin
            r.b0 = st.held_lead | HIGH_BIT;
            r.b1 = b | HIGH_BIT;
         end else begin
            r.b0 = st.held_lead;
            r.b1 = b;
         end
         r.st.pair_waiting    = 1'b0;
         r.st.pair_is_shifted = 1'b0;
         r.st.held_lead       = '0;
      end else if (allow_esc && (b == CHAR_ESC)) begin
         r.st.escape_progress = 2'd1;
      end else if (b == CHAR_SO) begin
         r.st.shift_active = 1'b1;
      end else if (b == CHAR_SI) begin
         r.st.shift_active = 1'b0;
      end else if (st.shift_active) begin
         if (b == CHAR_SPACE) begin
            r.count = 2'd1;
            r.b0    = b;
         end else begin
            r.st.pair_waiting    = 1'b1;
            r.st.pair_is_shifted = 1'b1;
            r.st.held_lead       = b;
         end
      end else if (b inside {[LEAD_LO:LEAD_HI]}) begin
         r.st.pair_waiting    = 1'b1;
         r.st.pair_is_shifted = 1'b0;
         r.st.held_lead       = b;
      end else begin
         r.count = 2'd1;
         r.b0    = b & LOW_MASK;
      end
      return r;
   endfunction

   function automatic word_list_type append_words(word_list_type l, step_result_type r);
      word_list_type o;
      o = l;
      if ((r.count >= 2'd1) && (o.count < 3'(MAX_WORDS))) begin
         o.words[o.count[1:0]] = r.b0;
         o.count               = o.count + 3'd1;
      end
      if ((r.count >= 2'd2) && (o.count < 3'(MAX_WORDS))) begin
         o.words[o.count[1:0]] = r.b1;
         o.count               = o.count + 3'd1;
      end
      return o;
   endfunction

endpackage

>>> src/i2ke_decode.sv
// conversion of one input byte: escape matching, replay of a broken escape, words out
module i2ke_decode import i2ke_pkg::*; (
   input  conv_state_type state_cur,
   input  logic [7:0]     byte_in,
   output conv_state_type state_next,
   output word_list_type  words_out
);

   always_comb begin
      step_result_type r;
      conv_state_type  st;
      word_list_type   l;
      logic [1:0]      held;
      r    = '0;
      st   = state_cur;
      l    = '0;
      held = state_cur.escape_progress;
      if (held == 2'd0) begin
         r  = handle_byte(st, byte_in, 1'b1);
         st = r.st;
         l  = append_words(l, r);
      end else if (byte_in == ESC_SEQ[held]) begin
         st.escape_progress = (held == 2'd3) ? 2'd0 : held + 2'd1;
      end else begin
         // broken match: replay held bytes, the held esc may not restart a match
         st.escape_progress = 2'd0;
         r  = handle_byte(st, CHAR_ESC, 1'b0);
         st = r.st;
         l  = append_words(l, r);
         if (held >= 2'd2) begin
            r  = handle_byte(st, CHAR_DOLLAR, 1'b1);
            st = r.st;
            l  = append_words(l, r);
         end
         if (held == 2'd3) begin
            r  = handle_byte(st, CHAR_RPAREN, 1'b1);
            st = r.st;
            l  = append_words(l, r);
         end
         r  = handle_byte(st, byte_in, 1'b1);
         st = r.st;
         l  = append_words(l, r);
      end
      state_next = st;
      words_out  = l;
   end

endmodule

>>> src/iso2022kr_to_euckr_converter_top.sv
// top level of the iso-2022-kr to euc-kr byte stream converter
//
// Takes one ISO-2022-KR byte per input word and delivers the EUC-KR bytes it
// causes, zero to four words, with tlast on the last word caused by that input
// byte. An input byte is held in an input register and is converted
// combinationally into a small result buffer, whose words are sent in order.
// While every byte yields at most one word and the receiver is ready, one byte
// is taken and one word delivered per cycle. A byte that yields n words keeps
// the single output port busy until all n have left, and input is taken again
// once the last of them leaves. Bytes that yield nothing (SO, SI, escape bytes,
// lead bytes) produce no word and leave the output port free. Shift mode, a
// partial ESC $ ) C match and a pending lead byte are kept across any gap in the
// stream; they are never flushed on their own. No clearing pass is needed after reset.
module iso2022kr_to_euckr_converter_top import i2ke_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // input words
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   // result words
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // run_last
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // conversion state
   conv_state_type state_ff;
   conv_state_type state_in;

   // result buffer: words of one input byte, sent in order
   logic                      out_valid_ff;
   logic [MAX_WORDS-1:0][7:0] out_words_ff;
   logic [1:0]                out_idx_ff;
   logic [1:0]                out_last_idx_ff;

   word_list_type words;
   logic          buf_free;
   logic          proc_fire;
   logic          rsp_fire;

   i2ke_decode u_decode (
      .state_cur  (state_ff),
      .byte_in    (in_byte_ff),
      .state_next (state_in),
      .words_out  (words)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_words_ff[out_idx_ff];
   assign rsp_tlast  = (out_idx_ff == out_last_idx_ff);
   assign rsp_fire   = out_valid_ff & rsp_tready;

   // buffer can take the next byte's words when empty or its last word leaves now
   assign buf_free   = !out_valid_ff || (rsp_tready && rsp_tlast);
   assign proc_fire  = in_valid_ff & buf_free;
   assign req_tready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         state_ff        <= '0;
         out_valid_ff    <= 1'b0;
         out_idx_ff      <= '0;
         out_last_idx_ff <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (proc_fire) begin
            state_ff <= state_in;
            if (words.count != 3'd0) begin
               out_valid_ff    <= 1'b1;
               out_idx_ff      <= '0;
               out_last_idx_ff <= 2'(words.count - 3'd1);
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (rsp_fire) begin
            if (rsp_tlast) begin
               out_valid_ff <= 1'b0;
            end else begin
               out_idx_ff <= out_idx_ff + 2'd1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (proc_fire) begin
         out_words_ff <= words.words;
      end
   end

endmodule

>>> bench/euckr_stream_checker.sv
// checker for the iso-2022-kr to euc-kr converter: predicts the euc-kr words and compares them
module euckr_stream_checker import i2ke_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   output int         error_count,
   output int         words_pending
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } euc_word_type;

   euc_word_type euc_expected[$];
   logic [7:0]   run_bytes[$];

   // converter state as predicted
   logic       shift_on;
   logic [1:0] esc_matched;
   logic       lead_pending;
   logic       lead_shifted;
   logic [7:0] lead_byte;

   // one byte through the conversion rules, esc_ok = 0 for a replayed escape
   function automatic void apply_rule(logic [7:0] b, bit esc_ok);
      if (lead_pending) begin
         if (lead_shifted) begin
            run_bytes.push_back(lead_byte | HIGH_BIT);
            run_bytes.push_back(b | HIGH_BIT);
         end else begin
            run_bytes.push_back(lead_byte);
            run_bytes.push_back(b);
         end
         lead_pending = 1'b0;
         lead_shifted = 1'b0;
         lead_byte    = '0;
      end else if (esc_ok && b == CHAR_ESC) begin
         esc_matched = 2'd1;
      end else if (b == CHAR_SO) begin
         shift_on = 1'b1;
      end else if (b == CHAR_SI) begin
         shift_on = 1'b0;
      end else if (shift_on) begin
         if (b == CHAR_SPACE) begin
            run_bytes.push_back(b);
         end else begin
            lead_pending = 1'b1;
            lead_shifted = 1'b1;
            lead_byte    = b;
         end
      end else if (b >= LEAD_LO && b <= LEAD_HI) begin
         lead_pending = 1'b1;
         lead_shifted = 1'b0;
         lead_byte    = b;
      end else begin
         run_bytes.push_back(b & LOW_MASK);
      end
   endfunction

   // expected euc-kr words for one accepted input byte
   function automatic void predict_euc_words(logic [7:0] b);
      int           held;
      euc_word_type w;
      run_bytes.delete();
      if (esc_matched == 2'd0) begin
         apply_rule(b, 1'b1);
      end else if (b == ESC_SEQ[esc_matched]) begin
         esc_matched = (esc_matched == 2'd3) ? 2'd0 : esc_matched + 2'd1;
      end else begin
         // broken designator: replay the held bytes, then the breaking byte
         held        = esc_matched;
         esc_matched = 2'd0;
         apply_rule(ESC_SEQ[0], 1'b0);
         for (int i = 1; i < held; i++)
            apply_rule(ESC_SEQ[i], 1'b1);
         apply_rule(b, 1'b1);
      end
      for (int i = 0; i < run_bytes.size() && i < MAX_WORDS; i++) begin
         w.data = run_bytes[i];
         w.last = (i == run_bytes.size() - 1) || (i == MAX_WORDS - 1);
         euc_expected.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      euc_word_type w;
      if (reset) begin
         shift_on     = 1'b0;
         esc_matched  = 2'd0;
         lead_pending = 1'b0;
         lead_shifted = 1'b0;
         lead_byte    = '0;
         euc_expected.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_euc_words(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (euc_expected.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               w = euc_expected.pop_front();
               if (w.data !== rsp_tdata) begin
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, w.data, rsp_tdata);
                  error_count++;
               end
               if (w.last !== rsp_tlast) begin
                  $display("%0t: run_last mismatch, expected %0b, actual %0b",
                           $time, w.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
      words_pending = euc_expected.size();
   end

endmodule

>>> bench/tb.sv
// testbench top of the iso-2022-kr to euc-kr converter: stimulus, idling and verdict
module tb import i2ke_pkg::*; ();

   // generous cycle limit, far above the slowest correct run
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 400;
   localparam int DRAIN_CYCLES  = 8;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   int error_count;
   int words_pending;
   int items_sent   = 0;
   int send_idle    = 0;   // percent of cycles the sender holds back
   int recv_stall   = 0;   // percent of cycles the receiver stalls

   // idling per phase: none, sender only, receiver only, both
   int phase_idle[4]  = '{0, 58, 0, 28};
   int phase_stall[4] = '{0, 0, 58, 28};

   iso2022kr_to_euckr_converter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // watches both channels, predicts and compares
   euckr_stream_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .words_pending (words_pending)
   );

   // 10 unit clock
   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // hard stop if the run hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // one input word: optional idle gap, then hold valid until accepted
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // mostly well-formed iso-2022-kr fragments with random content, plus noise
   task automatic send_random_sequence();
      int kind;
      int n;
      kind = $urandom_range(99);
      if (kind < 10) begin
         // full designator, dropped from the stream
         for (int i = 0; i < 4; i++) send_byte(ESC_SEQ[i]);
      end else if (kind < 20) begin
         send_byte($urandom_range(1) ? CHAR_SO : CHAR_SI);
      end else if (kind < 40) begin
         // ascii run
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) send_byte(8'($urandom_range(8'h7F)));
      end else if (kind < 55) begin
         // shifted hangul pair in 7-bit form
         send_byte(8'($urandom_range(8'h21, 8'h7E)));
         send_byte(8'($urandom_range(8'h21, 8'h7E)));
      end else if (kind < 65) begin
         // euc lead byte with an arbitrary partner
         send_byte(8'($urandom_range(LEAD_LO, LEAD_HI)));
         send_byte(8'($urandom_range(255)));
      end else if (kind < 73) begin
         // designator broken after one to three bytes
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++) send_byte(ESC_SEQ[i]);
         send_byte(8'($urandom_range(255)));
      end else if (kind < 80) begin
         send_byte(CHAR_SPACE);
      end else begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   // directed bytes: field extremes, lead range edges, partners that are
   // control bytes, replays at each depth, and the four-word replay in shift mode
   logic [7:0] directed_bytes[] = '{
      8'h1B, 8'h24, 8'h29, 8'h43,           // designator dropped
      8'h00, 8'h7F, 8'hFF, 8'hA0,           // extremes and just below lead range
      8'hA1, 8'h1B,                         // lead with esc as partner
      8'hFE, 8'h0E,                         // lead with so as partner
      8'h0E, 8'h20,                         // enter shift, space passes
      8'h45, 8'h20,                         // shifted pair, space partner
      8'h7F, 8'h0F,                         // shifted pair, si partner
      8'h1B, 8'h24, 8'h29, 8'h58,           // replay in shift mode, four words
      8'h0F,
      8'h1B, 8'h1B, 8'h24, 8'h41,           // esc breaks esc, then break after two
      8'h1B, 8'h24, 8'h29, 8'h0E,           // break after three, so from replay
      8'h0F
   };

   initial begin
      int per_phase;
      // reset held, then released at a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      per_phase = RANDOM_ITEMS / 4;
      for (int p = 0; p < 4; p++) begin
         send_idle  = phase_idle[p];
         recv_stall = phase_stall[p];
         if (p == 0)
            foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
         while (items_sent < directed_bytes.size() + per_phase * (p + 1))
            send_random_sequence();
      end
      req_tvalid <= 1'b0;

      // drain outstanding words, then let the pipeline settle
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
